[rtl/split_block_bloom_filter_macros.svh]
`ifndef SPLIT_BLOCK_BLOOM_FILTER_MACROS_SVH
`define SPLIT_BLOCK_BLOOM_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SBBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbbf: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SBBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbbf: next-cycle check failed");

`endif

[rtl/sbbf_pkg.sv]
`default_nettype none

package sbbf_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NB_W       = 11;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int NBE_W      = (CNT_W > NB_W) ? CNT_W : NB_W;
    localparam int WORDS      = 8;
    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = WORDS * WORD_W;
    localparam int MASK_SHIFT = 27;
    localparam int POS_W      = WORD_W - MASK_SHIFT;
    localparam int HASH_W     = 64;
    localparam int HALF_W     = HASH_W / 2;

    localparam logic [WORD_W-1:0] SALT [WORDS] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef logic [WORDS-1:0][POS_W-1:0] t_pos;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic mem_write;
        logic load_result;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic out_blocked;
    } t_sts;

    // bit position within word i: top bits of the low 32 bits of key * salt
    function automatic logic [POS_W-1:0] salt_pos(input logic [WORD_W-1:0] key,
                                                  input int unsigned idx);
        logic [WORD_W-1:0] prod;
        prod = key * SALT[idx];
        return prod[WORD_W-1 -: POS_W];
    endfunction

    function automatic logic [BLOCK_W-1:0] make_mask(input t_pos pos);
        logic [BLOCK_W-1:0] mask;
        for (int i = 0; i < WORDS; i++) begin
            mask[i*WORD_W +: WORD_W] = WORD_W'(1) << pos[i];
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

[rtl/sbbf_ram.sv]
`default_nettype none

module sbbf_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/sbbf_ctrl.sv]
`default_nettype none

module sbbf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire sbbf_pkg::t_sts  i_sts,
    output logic                 o_in_ready,
    output sbbf_pkg::t_cmd       o_cmd
);

    sbbf_pkg::t_state r_state;
    sbbf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbbf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbbf_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = sbbf_pkg::ST_IDLE;
            end
            sbbf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sbbf_pkg::ST_READ;
            end
            sbbf_pkg::ST_READ: begin
                n_state = sbbf_pkg::ST_EVAL;
            end
            sbbf_pkg::ST_EVAL: begin
                // a query holds here until the result register frees up
                if (!i_sts.is_query || !i_sts.out_blocked) n_state = sbbf_pkg::ST_IDLE;
            end
            default: n_state = sbbf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.clr_en      = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.mem_write   = 1'b0;
        o_cmd.load_result = 1'b0;
        case (r_state)
            sbbf_pkg::ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            sbbf_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            sbbf_pkg::ST_READ: begin
            end
            sbbf_pkg::ST_EVAL: begin
                o_cmd.mem_write   = !i_sts.is_query;
                o_cmd.load_result = i_sts.is_query && !i_sts.out_blocked;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/sbbf_dp.sv]
`default_nettype none

module sbbf_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sbbf_pkg::t_cmd                i_cmd,
    output sbbf_pkg::t_sts                     o_sts,
    input  wire logic                          i_op,
    input  wire logic [sbbf_pkg::HASH_W-1:0]   i_hash,
    input  wire logic                          i_cfg_we,
    input  wire logic [sbbf_pkg::NB_W-1:0]     i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_may_contain
);

    localparam int PROD_W = sbbf_pkg::HALF_W + sbbf_pkg::NBE_W;

    logic [sbbf_pkg::NB_W-1:0]    r_num_blocks;
    logic [sbbf_pkg::BLK_W-1:0]   r_clr_cnt;
    logic [sbbf_pkg::BLK_W-1:0]   r_idx;
    sbbf_pkg::t_pos               r_pos;
    logic                         r_op;
    logic                         r_out_valid;
    logic                         r_may_contain;

    logic [sbbf_pkg::NBE_W-1:0]   nb_raw;
    logic [sbbf_pkg::NBE_W-1:0]   nb_eff;
    logic [PROD_W-1:0]            prod;
    sbbf_pkg::t_pos               n_pos;
    logic [sbbf_pkg::BLOCK_W-1:0] rdata;
    logic [sbbf_pkg::BLOCK_W-1:0] mask;
    logic [sbbf_pkg::BLOCK_W-1:0] wdata;
    logic [sbbf_pkg::BLK_W-1:0]   waddr;
    logic                         we;
    logic                         hit;

    // blocks in use, held to 1..MAX_BLOCKS
    always_comb begin
        nb_raw = sbbf_pkg::NBE_W'(r_num_blocks);
        if (nb_raw == '0) begin
            nb_eff = sbbf_pkg::NBE_W'(1);
        end else if (nb_raw > sbbf_pkg::NBE_W'(sbbf_pkg::MAX_BLOCKS)) begin
            nb_eff = sbbf_pkg::NBE_W'(sbbf_pkg::MAX_BLOCKS);
        end else begin
            nb_eff = nb_raw;
        end
    end

    assign prod = PROD_W'(i_hash[sbbf_pkg::HASH_W-1:sbbf_pkg::HALF_W]) * PROD_W'(nb_eff);

    always_comb begin
        for (int i = 0; i < sbbf_pkg::WORDS; i++) begin
            n_pos[i] = sbbf_pkg::salt_pos(i_hash[sbbf_pkg::HALF_W-1:0], i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks <= sbbf_pkg::NB_W'(1);
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_num_blocks <= i_cfg_data;
            if (i_cmd.clr_en) r_clr_cnt <= r_clr_cnt + sbbf_pkg::BLK_W'(1);
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // quotient is below the block count, so the low bits above 32 are the index
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= prod[sbbf_pkg::HALF_W +: sbbf_pkg::BLK_W];
            r_pos <= n_pos;
            r_op  <= i_op;
        end
        if (i_cmd.load_result) r_may_contain <= hit;
    end

    assign mask = sbbf_pkg::make_mask(r_pos);

    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < sbbf_pkg::WORDS; i++) begin
            if ((rdata[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W]
                 & mask[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W]) == '0) hit = 1'b0;
        end
    end

    assign we    = i_cmd.clr_en || i_cmd.mem_write;
    assign waddr = i_cmd.clr_en ? r_clr_cnt : r_idx;
    assign wdata = i_cmd.clr_en ? '0 : (rdata | mask);

    sbbf_ram #(
        .WIDTH (sbbf_pkg::BLOCK_W),
        .DEPTH (sbbf_pkg::MAX_BLOCKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign o_sts.clr_last    = (r_clr_cnt == sbbf_pkg::BLK_W'(sbbf_pkg::MAX_BLOCKS - 1));
    assign o_sts.is_query    = (r_op == sbbf_pkg::OP_QUERY);
    assign o_sts.out_blocked = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_may_contain = r_may_contain;

endmodule

`default_nettype wire

[rtl/split_block_bloom_filter.sv]
// Channel   Direction  Payload (lowest bit first)             Transfer when
// s_axis    in         tdata: hash[63:0]; tuser: op            tvalid & tready
// m_axis    out        tdata: may_contain, 7 zero bits         tvalid & tready
// cfg       in         data: num_blocks[10:0]                  valid & ready
//
// An item goes through capture (block and bit positions worked out), read of the
// block store, then evaluate (insert writes the merged block back; query loads
// the result register) before the next transfer is accepted. The single write
// port and registered read of the block RAM set this sequence of steps.
// After reset the store is cleared one block a cycle, all 1024 blocks, with ready low.
// A query waits in evaluate while an earlier result is still not taken.
`default_nettype none
`include "split_block_bloom_filter_macros.svh"

module split_block_bloom_filter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [sbbf_pkg::HASH_W-1:0]  i_s_axis_tdata,  // hash
    input  wire logic                         i_s_axis_tuser,  // op
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [7:0]                   o_m_axis_tdata,  // may_contain, zero pad
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [sbbf_pkg::NB_W-1:0]    i_cfg_data       // num_blocks
);

    sbbf_pkg::t_cmd cmd;
    sbbf_pkg::t_sts sts;
    logic           may_contain;

    assign o_cfg_ready = 1'b1;

    sbbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    sbbf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_s_axis_tuser),
        .i_hash        (i_s_axis_tdata),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_may_contain (may_contain)
    );

    assign o_m_axis_tdata = {7'b0, may_contain};

    `SBBF_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, cmd.clr_en, !o_s_axis_tready)
    `SBBF_ASSERT_NOW(a_write_exclusive, i_clk, i_rst_n, cmd.mem_write, !cmd.clr_en)
    `SBBF_ASSERT_NOW(a_no_result_overwrite, i_clk, i_rst_n, cmd.load_result, !sts.out_blocked)
    `SBBF_ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

`default_nettype wire
